// ----- design/pps_pkg.sv -----
`timescale 1ns / 1ps

package pps_pkg;

    localparam int MAX_TASKS = 16;

    localparam int TIME_W  = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 7;
    localparam int KIND_W  = 2;
    localparam int TIDX_W  = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // result kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_OK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_REJ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RAN      = 2'd3;

    // request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  arr;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] left;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/pps_req_if.sv -----
`timescale 1ns / 1ps

interface pps_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [pps_pkg::TIME_W-1:0]   arrival_time;
    logic [pps_pkg::BURST_W-1:0]  burst_time;
    logic [pps_pkg::PRIO_W-1:0]   priority_req;

    modport source (
        output valid, req_type, arrival_time, burst_time, priority_req,
        input  ready
    );
    modport sink (
        input  valid, req_type, arrival_time, burst_time, priority_req,
        output ready
    );
endinterface

// ----- design/pps_rsp_if.sv -----
`timescale 1ns / 1ps

interface pps_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pps_pkg::KIND_W-1:0]   kind;
    logic [pps_pkg::TIDX_W-1:0]   task_index;
    logic [pps_pkg::TIME_W-1:0]   time_now;
    logic                         task_finished;
    logic [pps_pkg::TIME_W-1:0]   turnaround;
    logic [pps_pkg::TIME_W-1:0]   waiting;
    logic                         all_done;

    modport source (
        output valid, kind, task_index, time_now, task_finished, turnaround,
               waiting, all_done,
        input  ready
    );
    modport sink (
        input  valid, kind, task_index, time_now, task_finished, turnaround,
               waiting, all_done,
        output ready
    );
endinterface

// ----- design/pps_ram.sv -----
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = pps_pkg::ENTRY_W,
    parameter int DEPTH = pps_pkg::MAX_TASKS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/preemptive_priority_scheduler_unit.sv -----
`timescale 1ns / 1ps
// channel  dir  payload                                           beat when
// req      in   req_type arrival_time burst_time priority_req     valid && ready
// rsp      out  kind task_index time_now task_finished            valid && ready
//               turnaround waiting all_done
//
// A load is accepted, then the table write and the result follow together.
// A tick is accepted, then runs one table read per loaded task
// through the single read port and comparator, a drain step,
// then the update of the winner and the result.
// req.ready is high only while the sequencer idles; a stalled rsp holds the
// sequencer in its last step. rst_n clears counters, time and control; the
// table itself is not cleared (only written entries are ever used).

module preemptive_priority_scheduler_unit #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS
) (
    input  logic      clk,
    input  logic      rst_n,
    pps_req_if.sink   req,
    pps_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    state_reg;
    logic [CNT_W-1:0]              task_count_reg;
    logic [CNT_W-1:0]              fin_count_reg;
    logic [pps_pkg::TIME_W-1:0]    time_reg;
    logic                          ticks_started_reg;
    logic [CNT_W-1:0]              scan_cnt_reg;
    logic                          rd_pend_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    pps_pkg::entry_t               best_reg;
    pps_pkg::entry_t               load_reg;

    logic                          out_valid_reg;
    logic [pps_pkg::KIND_W-1:0]    out_kind_reg;
    logic [pps_pkg::TIDX_W-1:0]    out_idx_reg;
    logic [pps_pkg::TIME_W-1:0]    out_time_reg;
    logic                          out_fin_reg;
    logic [pps_pkg::TIME_W-1:0]    out_tat_reg;
    logic [pps_pkg::TIME_W-1:0]    out_wt_reg;
    logic                          out_all_reg;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    pps_pkg::entry_t               ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    logic [pps_pkg::ENTRY_W-1:0]   ram_rdata;
    pps_pkg::entry_t               rd_entry;

    logic                          out_free;
    logic                          out_load;
    logic                          req_beat;
    logic                          load_rej;
    logic [pps_pkg::TIME_W-1:0]    time_next;
    logic [pps_pkg::BURST_W-1:0]   left_dec;
    logic                          task_done;
    logic [pps_pkg::TIME_W-1:0]    tat;
    logic [pps_pkg::TIME_W-1:0]    wt;
    logic                          eligible;
    logic                          better;
    logic [IDX_W+pps_pkg::TIDX_W-1:0] load_idx_ext;
    logic [IDX_W+pps_pkg::TIDX_W-1:0] best_idx_ext;

    pps_ram #(
        .WIDTH (pps_pkg::ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = pps_pkg::entry_t'(ram_rdata);
    assign ram_raddr = scan_cnt_reg[IDX_W-1:0];

    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = out_free && ((state_reg == ST_LOAD) || (state_reg == ST_DONE));
    assign req.ready = (state_reg == ST_IDLE);
    assign req_beat  = req.valid && req.ready;

    assign load_rej = ticks_started_reg || (load_reg.burst == '0)
                      || (task_count_reg >= CNT_MAX);

    assign time_next = (time_reg == pps_pkg::TIME_MAX) ? time_reg : time_reg + 1'b1;
    assign left_dec  = best_reg.left - 1'b1;
    assign task_done = (left_dec == '0);
    assign tat       = time_next - best_reg.arr;
    assign wt        = (tat >= best_reg.burst) ? tat - best_reg.burst : '0;

    assign eligible = (rd_entry.left != '0) && (rd_entry.arr <= time_reg);
    assign better   = !found_reg || (rd_entry.prio < best_reg.prio)
                      || ((rd_entry.prio == best_reg.prio) && (rd_entry.arr < best_reg.arr));

    assign load_idx_ext = {{pps_pkg::TIDX_W{1'b0}}, task_count_reg[IDX_W-1:0]};
    assign best_idx_ext = {{pps_pkg::TIDX_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = best_reg;
        case (state_reg)
            ST_LOAD:
            begin
                ram_we    = out_free && !load_rej;
                ram_waddr = task_count_reg[IDX_W-1:0];
                ram_wdata = load_reg;
            end
            ST_DONE:
            begin
                ram_we         = out_free && found_reg;
                ram_waddr      = best_idx_reg;
                ram_wdata      = best_reg;
                ram_wdata.left = left_dec;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            load_reg.arr   <= req.arrival_time;
            load_reg.burst <= req.burst_time;
            load_reg.left  <= req.burst_time;
            load_reg.prio  <= req.priority_req;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
            if (rd_pend_reg && eligible && better)
            begin
                best_reg     <= rd_entry;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (state_reg == ST_LOAD && out_free)
        begin
            out_kind_reg <= load_rej ? pps_pkg::KIND_LOAD_REJ : pps_pkg::KIND_LOAD_OK;
            out_idx_reg  <= load_rej ? '0 : load_idx_ext[pps_pkg::TIDX_W-1:0];
            out_time_reg <= time_reg;
            out_fin_reg  <= 1'b0;
            out_tat_reg  <= '0;
            out_wt_reg   <= '0;
            out_all_reg  <= load_rej ? (fin_count_reg == task_count_reg)
                                     : (fin_count_reg == task_count_reg + 1'b1);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_time_reg <= time_next;
            if (!found_reg)
            begin
                out_kind_reg <= pps_pkg::KIND_IDLE;
                out_idx_reg  <= '0;
                out_fin_reg  <= 1'b0;
                out_tat_reg  <= '0;
                out_wt_reg   <= '0;
                out_all_reg  <= (fin_count_reg == task_count_reg);
            end
            else
            begin
                out_kind_reg <= pps_pkg::KIND_RAN;
                out_idx_reg  <= best_idx_ext[pps_pkg::TIDX_W-1:0];
                out_fin_reg  <= task_done;
                out_tat_reg  <= task_done ? tat : '0;
                out_wt_reg   <= task_done ? wt : '0;
                out_all_reg  <= task_done ? (fin_count_reg + 1'b1 == task_count_reg)
                                          : (fin_count_reg == task_count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            task_count_reg    <= '0;
            fin_count_reg     <= '0;
            time_reg          <= '0;
            ticks_started_reg <= 1'b0;
            scan_cnt_reg      <= '0;
            rd_pend_reg       <= 1'b0;
            found_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_beat)
                    begin
                        if (req.req_type == pps_pkg::REQ_TICK)
                        begin
                            state_reg    <= ST_SCAN;
                            scan_cnt_reg <= '0;
                            rd_pend_reg  <= 1'b0;
                            found_reg    <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        if (!load_rej)
                        begin
                            task_count_reg <= task_count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    // read of entry n issued here is compared in the cycle after
                    if (rd_pend_reg && eligible)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (scan_cnt_reg < task_count_reg)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        rd_pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        time_reg          <= time_next;
                        ticks_started_reg <= 1'b1;
                        if (found_reg && task_done)
                        begin
                            fin_count_reg <= fin_count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.task_index    = out_idx_reg;
    assign rsp.time_now      = out_time_reg;
    assign rsp.task_finished = out_fin_reg;
    assign rsp.turnaround    = out_tat_reg;
    assign rsp.waiting       = out_wt_reg;
    assign rsp.all_done      = out_all_reg;

endmodule

// ----- design/pps_checker.sv -----
`timescale 1ns / 1ps

module pps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [pps_pkg::KIND_W-1:0]  kind,
    input logic [pps_pkg::TIDX_W-1:0]  task_index,
    input logic [pps_pkg::TIME_W-1:0]  time_now,
    input logic                        task_finished,
    input logic [pps_pkg::TIME_W-1:0]  turnaround,
    input logic [pps_pkg::TIME_W-1:0]  waiting
);

    // one item in flight: busy right after every request beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req.ready high in the cycle after a request beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(task_index)
                                    && $stable(time_now) && $stable(turnaround))
        else $error("stalled response changed");

    a_no_task_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == pps_pkg::KIND_IDLE || kind == pps_pkg::KIND_LOAD_REJ)
        |-> task_index == '0 && !task_finished)
        else $error("idle tick or rejected load carries task fields");

    a_fin_only_ran: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && task_finished |-> kind == pps_pkg::KIND_RAN)
        else $error("task_finished on a beat that ran no task");

    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> waiting <= turnaround)
        else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .kind          (rsp.kind),
    .task_index    (rsp.task_index),
    .time_now      (rsp.time_now),
    .task_finished (rsp.task_finished),
    .turnaround    (rsp.turnaround),
    .waiting       (rsp.waiting)
);
